// ----- rtl/hypergraph_spanning_column_select_defines.svh -----
// Assertion helpers shared by hsc_label_ram.sv and hsc_engine.sv.
`ifndef HYPERGRAPH_SPANNING_COLUMN_SELECT_DEFINES_SVH
`define HYPERGRAPH_SPANNING_COLUMN_SELECT_DEFINES_SVH

`ifndef SYNTHESIS
`define HSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define HSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define HSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/hsc_pkg.sv -----
package hsc_pkg;

	localparam int MAX_ROWS   = 62;
	localparam int INDEX_BITS = 12;

	localparam int NODE_W     = 6;
	localparam int NODE_COUNT = 1 << NODE_W;
	localparam int LOW_NODE   = MAX_ROWS;
	localparam int HIGH_NODE  = MAX_ROWS + 1;
	localparam int LABEL_W    = 6;

	localparam int S_TDATA_W = ((MAX_ROWS + INDEX_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = ((LABEL_W + INDEX_BITS + 7) / 8) * 8;
	localparam int M_TUSER_W = 3;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic REG_ROWS_IN_USE     = 1'b0;
	localparam logic REG_SELECTION_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_MERGE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic               clear;
		logic               re;
		logic [NODE_W-1:0]  raddr;
		logic               we;
		logic [NODE_W-1:0]  waddr;
		logic [LABEL_W-1:0] wdata;
	} ram_req_t;

	function automatic logic [LABEL_W-1:0] clamp_reg(input logic [LABEL_W-1:0] v);
		logic [LABEL_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = LABEL_W'(1);
		end else if ({1'b0, v} > (LABEL_W + 1)'(MAX_ROWS)) begin
			r = LABEL_W'(MAX_ROWS);
		end
		return r;
	endfunction

endpackage

// ----- rtl/hsc_label_ram.sv -----
`include "hypergraph_spanning_column_select_defines.svh"

module hsc_label_ram (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hsc_pkg::ram_req_t           req,
	output logic [hsc_pkg::LABEL_W-1:0] rdata
);
	import hsc_pkg::*;

	logic [LABEL_W-1:0]    mem [NODE_COUNT];
	logic [NODE_COUNT-1:0] vld_q;
	logic [LABEL_W-1:0]    rdata_q;
	logic                  rvld_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	// Entries never written since the last clear read as unlabelled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.clear) begin
				vld_q <= '0;
			end else if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rvld_q <= vld_q[req.raddr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

	`HSC_ASSERT_IMP(a_no_same_addr, clk, arst_n, req.we && req.re, req.waddr != req.raddr)
	`HSC_ASSERT_IMP(a_clear_no_access, clk, arst_n, req.clear, !req.we && !req.re)
	`HSC_ASSERT_NXT(a_clear_empties, clk, arst_n, req.clear, vld_q == '0)

endmodule

// ----- rtl/hsc_engine.sv -----
`include "hypergraph_spanning_column_select_defines.svh"

module hsc_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [hsc_pkg::LABEL_W-1:0]   rows_in_use,
	input  logic [hsc_pkg::LABEL_W-1:0]   selection_limit,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hsc_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hsc_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [hsc_pkg::M_TUSER_W-1:0] m_tuser,
	output hsc_pkg::ram_req_t             ram_req,
	input  logic [hsc_pkg::LABEL_W-1:0]   ram_rdata
);
	import hsc_pkg::*;

	state_t state_q, state_d;

	logic [NODE_W:0]         cnt_q;
	logic                    rd_s1;
	logic [NODE_W-1:0]       idx_s1;
	logic [MAX_ROWS-1:0]     bits_q;
	logic [INDEX_BITS-1:0]   index_q;
	logic [NODE_COUNT-1:0]   touched_q;
	logic [NODE_COUNT-1:0]   seen_q;
	logic                    loop_q;
	logic [1:0]              lab_cnt_q;
	logic [LABEL_W-1:0]      one_label_q;
	logic [LABEL_W-1:0]      next_label_q;
	logic [LABEL_W-1:0]      count_q;
	logic                    res_acc_q;
	logic                    res_loop_q;
	logic                    res_done_q;
	logic [LABEL_W-1:0]      res_slot_q;
	logic                    m_tvalid_q;
	logic [M_TDATA_W-1:0]    m_tdata_q;
	logic [M_TUSER_W-1:0]    m_tuser_q;

	logic [LABEL_W-1:0]      ru;
	logic [LABEL_W-1:0]      lim;
	logic [MAX_ROWS-1:0]     row_mask;
	logic [MAX_ROWS-1:0]     low_mask;
	logic [MAX_ROWS-1:0]     nodes_raw;
	logic                    single_bit;
	logic [NODE_COUNT-1:0]   touched_d;
	logic                    done_now;
	logic                    s_accept;
	logic                    out_free;
	logic                    hit;
	logic                    loop_d;
	logic                    single;
	logic [LABEL_W-1:0]      count_inc;
	logic                    last_node;

	assign ru  = clamp_reg(rows_in_use);
	assign lim = clamp_reg(selection_limit);

	always_comb begin
		for (int r = 0; r < MAX_ROWS; r++) begin
			row_mask[r] = {1'b0, ru} > (LABEL_W + 1)'(r);
			low_mask[r] = {2'b0, ru[LABEL_W-1:1]} > (LABEL_W + 1)'(r);
		end
	end

	// A column that touches one row also touches the boundary on that row's side.
	assign nodes_raw  = bits_q & row_mask;
	assign single_bit = (nodes_raw != '0) && ((nodes_raw & (nodes_raw - 1'b1)) == '0);

	always_comb begin
		touched_d = '0;
		touched_d[MAX_ROWS-1:0] = nodes_raw;
		if (single_bit) begin
			if ((nodes_raw & low_mask) != '0) begin
				touched_d[LOW_NODE] = 1'b1;
			end else begin
				touched_d[HIGH_NODE] = 1'b1;
			end
		end
	end

	assign done_now  = count_q >= lim;
	assign s_tready  = state_q == ST_IDLE;
	assign s_accept  = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign last_node = cnt_q[NODE_W];
	assign single    = lab_cnt_q == 2'd1;
	assign count_inc = count_q + 1'b1;

	assign hit    = (state_q == ST_SCAN) && rd_s1 && touched_q[idx_s1] && (ram_rdata != '0);
	assign loop_d = loop_q || (hit && seen_q[ram_rdata]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ram_req.clear = s_accept && s_tuser[0];
		ram_req.re    = ((state_q == ST_SCAN) || (state_q == ST_MERGE)) && !last_node;
		ram_req.raddr = cnt_q[NODE_W-1:0];
		ram_req.we    = 1'b0;
		ram_req.waddr = idx_s1;
		ram_req.wdata = single ? one_label_q : next_label_q;
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = done_now ? ST_FINISH : ST_SCAN;
			end
			ST_SCAN: begin
				if (last_node) begin
					state_d = loop_d ? ST_FINISH : ST_MERGE;
				end
			end
			ST_MERGE: begin
				ram_req.we = rd_s1 && (touched_q[idx_s1] ||
					((ram_rdata != '0) && seen_q[ram_rdata] && !single));
				if (last_node) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			bits_q  <= s_tdata[MAX_ROWS-1:0];
			index_q <= s_tdata[MAX_ROWS +: INDEX_BITS];
		end
		idx_s1 <= ram_req.raddr;
		if (state_q == ST_PREP) begin
			touched_q <= touched_d;
		end
		if (hit) begin
			one_label_q <= ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			rd_s1        <= 1'b0;
			seen_q       <= '0;
			loop_q       <= 1'b0;
			lab_cnt_q    <= '0;
			next_label_q <= LABEL_W'(1);
			count_q      <= '0;
			res_acc_q    <= 1'b0;
			res_loop_q   <= 1'b0;
			res_done_q   <= 1'b0;
			res_slot_q   <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= '0;
		end else begin
			rd_s1 <= ram_req.re;
			cnt_q <= ram_req.re ? cnt_q + 1'b1 : '0;
			if (ram_req.clear) begin
				next_label_q <= LABEL_W'(1);
				count_q      <= '0;
			end
			case (state_q)
				ST_PREP: begin
					seen_q     <= '0;
					loop_q     <= 1'b0;
					lab_cnt_q  <= '0;
					res_acc_q  <= 1'b0;
					res_loop_q <= 1'b0;
					res_slot_q <= '0;
					res_done_q <= done_now;
				end
				ST_SCAN: begin
					loop_q <= loop_d;
					if (hit) begin
						seen_q[ram_rdata] <= 1'b1;
						if (lab_cnt_q != 2'd2) begin
							lab_cnt_q <= lab_cnt_q + 1'b1;
						end
					end
					if (last_node) begin
						res_loop_q <= loop_d;
					end
				end
				ST_MERGE: begin
					if (last_node) begin
						res_acc_q  <= 1'b1;
						res_slot_q <= count_q;
						count_q    <= count_inc;
						res_done_q <= count_inc >= lim;
						if (!single) begin
							next_label_q <= next_label_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
			if ((state_q == ST_FINISH) && out_free) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= M_TDATA_W'({index_q, res_slot_q});
				m_tuser_q  <= {res_done_q, res_loop_q, res_acc_q};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`HSC_ASSERT_IMP(a_acc_xor_loop, clk, arst_n, m_tvalid_q, !(m_tuser_q[0] && m_tuser_q[1]))
	`HSC_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, {1'b0, count_q} <= (LABEL_W + 1)'(MAX_ROWS))
	`HSC_ASSERT_IMP(a_write_in_merge, clk, arst_n, ram_req.we, state_q == ST_MERGE)

endmodule

// ----- rtl/hypergraph_spanning_column_select.sv -----
// Channel   Direction  Contents
// s_*       in         column request: tdata = column_bits, column_index; tuser = start_req
// m_*       out        column result: tdata = slot, source_column; tuser = flags
// APB       in         rows_in_use at 0x0, selection_limit at 0x4
//
// A column that is checked and merged is captured, has its touched node set formed, has
// the label memory scanned, is relabelled through its single read and write port, and
// has its result loaded. A column rejected as a loop skips the relabel walk, and one
// arriving once the limit is reached skips both the scan and the relabel walk. A stalled
// result holds the block in its last step. Reset clears every label at once through
// per-entry valid bits, as does start_req.

module hypergraph_spanning_column_select (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hsc_pkg::PADDR_W-1:0]   paddr,
	input  logic [hsc_pkg::PDATA_W-1:0]   pwdata,
	output logic [hsc_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// column_bits, column_index, zero fill
	input  logic [hsc_pkg::S_TDATA_W-1:0] s_tdata,
	// start_req
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// slot, source_column, zero fill
	output logic [hsc_pkg::M_TDATA_W-1:0] m_tdata,
	// accepted, loop_found, done_res
	output logic [hsc_pkg::M_TUSER_W-1:0] m_tuser
);
	import hsc_pkg::*;

	logic [LABEL_W-1:0] rows_in_use_q;
	logic [LABEL_W-1:0] selection_limit_q;
	logic               reg_wr;
	ram_req_t           ram_req;
	logic [LABEL_W-1:0] ram_rdata;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q     <= LABEL_W'(MAX_ROWS);
			selection_limit_q <= LABEL_W'(MAX_ROWS);
		end else if (reg_wr) begin
			case (paddr[2])
				REG_ROWS_IN_USE: begin
					rows_in_use_q <= pwdata[LABEL_W-1:0];
				end
				REG_SELECTION_LIMIT: begin
					selection_limit_q <= pwdata[LABEL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ROWS_IN_USE:     prdata = PDATA_W'(rows_in_use_q);
			REG_SELECTION_LIMIT: prdata = PDATA_W'(selection_limit_q);
			default:             prdata = '0;
		endcase
	end

	hsc_engine u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.rows_in_use     (rows_in_use_q),
		.selection_limit (selection_limit_q),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.ram_req         (ram_req),
		.ram_rdata       (ram_rdata)
	);

	hsc_label_ram u_label_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.rdata  (ram_rdata)
	);

endmodule
